FILE: rtl/stereo_output_post_filter_top_assert.svh
// ----------------------------------------------------------------------------
// Stereo output post filter assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_OUTPUT_POST_FILTER_TOP_ASSERT_SVH
`define STEREO_OUTPUT_POST_FILTER_TOP_ASSERT_SVH

// property that holds at every clock edge outside reset
`define SOPF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent seen at one edge, consequent required at the next
`define SOPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

FILE: rtl/sopf_pkg.sv
// ----------------------------------------------------------------------------
// Stereo output post filter package
// Shared types, register codes and constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sopf_pkg;

	localparam int SAMPLE_WIDTH_DEF = 18;
	localparam int WORD_W           = 16;
	localparam int BYTE_W           = 8;
	localparam int REG_INDEX_W      = 2;
	localparam int CFG_DATA_W       = 2;

	localparam logic [BYTE_W-1:0] OFFSET_BYTE = 8'h80;
	localparam int BLEND_MAJOR = 11;
	localparam int BLEND_MINOR = 5;

	typedef enum logic [1:0] {
		MODE_BYPASS = 2'd0,
		MODE_LIGHT  = 2'd1,
		MODE_MEDIUM = 2'd2,
		MODE_HEAVY  = 2'd3
	} filter_mode_t;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_FILTER_MODE   = 2'd0,
		REG_BLEND_ENABLE  = 2'd1,
		REG_STEREO_ENABLE = 2'd2,
		REG_EIGHT_BIT     = 2'd3
	} reg_index_t;

	typedef struct packed {
		filter_mode_t filter_mode;
		logic         blend_enable;
		logic         stereo_enable;
		logic         eight_bit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		filter_mode:   MODE_LIGHT,
		blend_enable:  1'b1,
		stereo_enable: 1'b0,
		eight_bit:     1'b0
	};

endpackage

FILE: rtl/sopf_lane.sv
// ----------------------------------------------------------------------------
// Stereo output post filter lane
// One-pole low-pass filter, or bypass, for one channel with its own accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sopf_lane #(
	parameter int SAMPLE_WIDTH = sopf_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  sopf_pkg::filter_mode_t         mode,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic signed [SAMPLE_WIDTH-1:0] filtered
);
	import sopf_pkg::*;

	localparam int EW = SAMPLE_WIDTH + 2;

	logic signed [SAMPLE_WIDTH-1:0] acc_q;
	logic signed [EW-1:0]           x_ext;
	logic signed [EW-1:0]           s_ext;
	logic signed [EW-1:0]           sum;

	assign x_ext = {{2{sample[SAMPLE_WIDTH-1]}}, sample};
	assign s_ext = {{2{acc_q[SAMPLE_WIDTH-1]}}, acc_q};

	always_comb begin
		sum      = '0;
		filtered = sample;
		case (mode)
			MODE_LIGHT: begin
				sum      = (x_ext <<< 1) + x_ext + s_ext;
				filtered = sum[EW-1:2];
			end
			MODE_MEDIUM: begin
				sum      = x_ext + s_ext;
				filtered = sum[SAMPLE_WIDTH:1];
			end
			MODE_HEAVY: begin
				sum      = x_ext + (s_ext <<< 1) + s_ext;
				filtered = sum[EW-1:2];
			end
			default: begin
				sum      = '0;
				filtered = sample;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (advance && mode != MODE_BYPASS) begin
			acc_q <= filtered;
		end
	end

endmodule

FILE: rtl/sopf_merge.sv
// ----------------------------------------------------------------------------
// Stereo output post filter merge
// Cross-blend of the two lanes and packing into output words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sopf_merge #(
	parameter int SAMPLE_WIDTH = sopf_pkg::SAMPLE_WIDTH_DEF
) (
	input  sopf_pkg::cfg_t                 cfg,
	input  logic signed [SAMPLE_WIDTH-1:0] left,
	input  logic signed [SAMPLE_WIDTH-1:0] right,
	output logic [sopf_pkg::WORD_W-1:0]    first_word,
	output logic [sopf_pkg::WORD_W-1:0]    second_word
);
	import sopf_pkg::*;

	localparam int BW = SAMPLE_WIDTH + 5;
	localparam int LW = SAMPLE_WIDTH + 1;
	localparam int MW = SAMPLE_WIDTH + 2;

	logic signed [BW-1:0] l_ext;
	logic signed [BW-1:0] r_ext;
	logic signed [BW-1:0] mix_l;
	logic signed [BW-1:0] mix_r;
	logic signed [LW-1:0] l_out;
	logic signed [LW-1:0] r_out;
	logic signed [MW-1:0] mono;

	assign l_ext = BW'(left);
	assign r_ext = BW'(right);
	assign mix_l = BW'(l_ext * BLEND_MAJOR + r_ext * BLEND_MINOR);
	assign mix_r = BW'(l_ext * BLEND_MINOR + r_ext * BLEND_MAJOR);

	always_comb begin
		if (cfg.blend_enable) begin
			l_out = mix_l[BW-1:4];
			r_out = mix_r[BW-1:4];
		end else begin
			l_out = LW'(left);
			r_out = LW'(right);
		end
		mono = MW'(l_out) + MW'(r_out);

		second_word = '0;
		if (cfg.stereo_enable) begin
			if (cfg.eight_bit) begin
				first_word  = WORD_W'(l_out[15:8] ^ OFFSET_BYTE);
				second_word = WORD_W'(r_out[15:8] ^ OFFSET_BYTE);
			end else begin
				first_word  = l_out[15:0];
				second_word = r_out[15:0];
			end
		end else if (cfg.eight_bit) begin
			first_word = WORD_W'(mono[16:9] ^ OFFSET_BYTE);
		end else begin
			first_word = mono[16:1];
		end
	end

endmodule

FILE: rtl/stereo_output_post_filter_top.sv
// ----------------------------------------------------------------------------
// Stereo output post filter
// Per-channel low-pass, optional cross-blend and packing of a stereo pair.
// ----------------------------------------------------------------------------
// Takes one stereo pair per clock while in_stall is low and returns exactly
// one packed beat per pair through the stage-1 and output registers. The
// left and right filter lanes run side by side; each keeps its accumulator
// in a register loop, which sets the rate at one pair per cycle. A merge
// stage blends the lanes and packs the words into the output register, so
// a new pair is taken while a finished beat still waits. Configuration
// writes take effect at once and belong while the pipeline is empty.
`timescale 1ns / 1ps

module stereo_output_post_filter_top #(
	parameter int SAMPLE_WIDTH = sopf_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [sopf_pkg::REG_INDEX_W-1:0]     wr_index,
	input  logic [sopf_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]       left_in,
	input  logic signed [SAMPLE_WIDTH-1:0]       right_in,
	input  logic                                 block_end,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sopf_pkg::WORD_W-1:0]          first_word,
	output logic [sopf_pkg::WORD_W-1:0]          second_word,
	output logic                                 block_end_out
);
	import sopf_pkg::*;

	cfg_t                           cfg_q;
	logic                           adv_s1;
	logic                           adv_s2;
	logic                           accept;
	logic signed [SAMPLE_WIDTH-1:0] left_filt;
	logic signed [SAMPLE_WIDTH-1:0] right_filt;
	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] left_s1;
	logic signed [SAMPLE_WIDTH-1:0] right_s1;
	logic                           block_end_s1;
	logic [WORD_W-1:0]              first_mrg;
	logic [WORD_W-1:0]              second_mrg;
	logic                           valid_s2;
	logic [WORD_W-1:0]              first_s2;
	logic [WORD_W-1:0]              second_s2;
	logic                           block_end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_FILTER_MODE:   cfg_q.filter_mode   <= filter_mode_t'(wr_data[1:0]);
				REG_BLEND_ENABLE:  cfg_q.blend_enable  <= wr_data[0];
				REG_STEREO_ENABLE: cfg_q.stereo_enable <= wr_data[0];
				REG_EIGHT_BIT:     cfg_q.eight_bit     <= wr_data[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign accept   = in_valid && adv_s1;

	sopf_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (accept),
		.mode     (cfg_q.filter_mode),
		.sample   (left_in),
		.filtered (left_filt)
	);

	sopf_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (accept),
		.mode     (cfg_q.filter_mode),
		.sample   (right_in),
		.filtered (right_filt)
	);

	sopf_merge #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_merge (
		.cfg         (cfg_q),
		.left        (left_s1),
		.right       (right_s1),
		.first_word  (first_mrg),
		.second_word (second_mrg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1      <= left_filt;
			right_s1     <= right_filt;
			block_end_s1 <= block_end;
		end
		if (adv_s2 && valid_s1) begin
			first_s2     <= first_mrg;
			second_s2    <= second_mrg;
			block_end_s2 <= block_end_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign first_word    = first_s2;
	assign second_word   = second_s2;
	assign block_end_out = block_end_s2;

endmodule

FILE: rtl/sopf_checker.sv
// ----------------------------------------------------------------------------
// Stereo output post filter checker
// Port-level checks on stalls, latency and beat hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stereo_output_post_filter_top_assert.svh"

module sopf_checker #(
	parameter int SAMPLE_WIDTH = sopf_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic signed [SAMPLE_WIDTH-1:0]   left_in,
	input logic signed [SAMPLE_WIDTH-1:0]   right_in,
	input logic                             block_end,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [sopf_pkg::WORD_W-1:0]      first_word,
	input logic [sopf_pkg::WORD_W-1:0]      second_word,
	input logic                             block_end_out
);

	// input stalls only when a full beat is held back at the output
	`SOPF_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (out_valid && out_stall), "input stalled without output backpressure")

	// an accepted pair reaches the output through the stage-1 and output registers when the output is free
	`SOPF_ASSERT(a_latency, clk, arst_n, ((in_valid && !in_stall) ##1 !out_stall) |=> (out_valid && block_end_out == $past(block_end, 2)), "beat missing or late")

	// hold a stalled output beat
	`SOPF_ASSERT_NEXT(a_out_hold, clk, arst_n, (out_valid && out_stall), (out_valid && $stable(first_word) && $stable(second_word) && $stable(block_end_out)), "stalled output changed")

	// hold a stalled input beat
	`SOPF_ASSERT_NEXT(a_in_hold, clk, arst_n, (in_valid && in_stall), (in_valid && $stable(left_in) && $stable(right_in) && $stable(block_end)), "stalled input changed")

endmodule

bind stereo_output_post_filter_top sopf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sopf_checker (.*);
